@@ rtl/audio_window_level_meter_defines.svh @@
// Assertion macros for the audio window level meter.
// Used by the checker; depends on nothing else.
`ifndef AUDIO_WINDOW_LEVEL_METER_DEFINES_SVH
`define AUDIO_WINDOW_LEVEL_METER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AWLM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("awlm assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define AWLM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("awlm assertion failed");

`endif

@@ rtl/awlm_pkg.sv @@
// Shared types, constants and the log2 table of the audio window level meter.
// Depends on nothing; every other file but the defines header imports it.
`default_nettype none

package awlm_pkg;

  localparam int SAMPLE_W        = 16;
  localparam int SUM_W           = 32;
  localparam int LOG_W           = 16;
  localparam int D_W             = 17;
  localparam int PROD_W          = 36;
  localparam int LEVEL_W         = 13;
  localparam int OUT_DATA_W      = 16;
  localparam int MAX_SAMPLES_DEF = 65536;

  localparam logic [17:0]              DB_FACTOR   = 18'd147962;
  localparam logic signed [D_W-1:0]    LOG_OFFSET  = 17'sd15360;
  localparam logic signed [PROD_W-1:0] ROUND_HALF  = 36'sd524288;
  localparam logic signed [LEVEL_W-1:0] LEVEL_TOP   = 13'sd1920;
  localparam logic signed [LEVEL_W-1:0] LEVEL_FLOOR = -13'sd2560;

  localparam logic [10:0] LOG_TAB [0:32] = '{
    11'd0,   11'd45,  11'd90,  11'd132, 11'd174, 11'd214, 11'd254, 11'd292,
    11'd330, 11'd366, 11'd402, 11'd436, 11'd470, 11'd504, 11'd536, 11'd568,
    11'd599, 11'd629, 11'd659, 11'd689, 11'd717, 11'd745, 11'd773, 11'd800,
    11'd827, 11'd853, 11'd879, 11'd904, 11'd929, 11'd953, 11'd977, 11'd1001,
    11'd1024
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM_GO,
    ST_SUM_WAIT,
    ST_CNT_GO,
    ST_CNT_WAIT,
    ST_SCALE,
    ST_CLAMP,
    ST_DONE
  } awlm_state_e;

  typedef struct packed {
    logic in_ready;
    logic log_start;
    logic sel_cnt;
    logic cap_lsum;
    logic cap_d;
    logic cap_prod;
    logic cap_level;
    logic cap_silent;
    logic load_out;
    logic clear_acc;
  } awlm_ctrl_t;

  typedef struct packed {
    logic end_req;
    logic log_done;
    logic is_silent;
    logic out_free;
  } awlm_stat_t;

endpackage

`default_nettype wire

@@ rtl/awlm_accum.sv @@
// Magnitude accumulator and sample counter of the level meter.
// Depends on awlm_pkg.
`default_nettype none

module awlm_accum
  import awlm_pkg::*;
#(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
  parameter int CNT_W       = $clog2(MAX_SAMPLES + 1)
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                add_i,
  input  wire logic [SAMPLE_W-1:0] sample_i,
  input  wire logic                clear_i,
  output logic      [SUM_W-1:0]    sum_o,
  output logic      [CNT_W-1:0]    count_o
);

  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [SAMPLE_W:0] mag;

  always_comb begin
    if (sample_i[SAMPLE_W-1]) begin
      mag = (SAMPLE_W+1)'(1 << SAMPLE_W) - {1'b0, sample_i};
    end else begin
      mag = {1'b0, sample_i};
    end
  end

  always_comb begin
    sum_d   = sum_q;
    count_d = count_q;
    if (clear_i) begin
      sum_d   = '0;
      count_d = '0;
    end else if (add_i && (count_q < CNT_W'(MAX_SAMPLES))) begin
      sum_d   = sum_q + SUM_W'(mag);
      count_d = count_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      count_q <= '0;
    end else begin
      sum_q   <= sum_d;
      count_q <= count_d;
    end
  end

  assign sum_o   = sum_q;
  assign count_o = count_q;

endmodule

`default_nettype wire

@@ rtl/awlm_log_unit.sv @@
// Shared fixed-point log2 unit (Q10): five-step leading-one search, then table
// interpolation. Depends on awlm_pkg for the table and widths.
`default_nettype none

module awlm_log_unit
  import awlm_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [SUM_W-1:0] x_i,
  output logic                  done_o,
  output logic      [LOG_W-1:0] result_o
);

  localparam logic [2:0] LAST_STEP = 3'd5;

  logic             busy_q, busy_d;
  logic [2:0]       step_q, step_d;
  logic [SUM_W-1:0] n_q, n_d;
  logic [4:0]       p_q, p_d;
  logic             done_q, done_d;
  logic [LOG_W-1:0] result_q, result_d;

  logic [4:0]       shamt;
  logic [SUM_W-1:0] hi_mask;
  logic [4:0]       idx;
  logic [7:0]       frac;
  logic [10:0]      lo, hi, diff;
  logic [18:0]      interp_prod;
  logic [10:0]      interp;

  always_comb begin
    shamt       = 5'd16 >> step_q;
    hi_mask     = ~({SUM_W{1'b1}} >> shamt);
    idx         = n_q[30:26];
    frac        = n_q[25:18];
    lo          = LOG_TAB[{1'b0, idx}];
    hi          = LOG_TAB[6'({1'b0, idx}) + 6'd1];
    diff        = hi - lo;
    interp_prod = 19'(diff * frac) + 19'd128;
    interp      = 11'(interp_prod >> 8);
  end

  always_comb begin
    busy_d   = busy_q;
    step_d   = step_q;
    n_d      = n_q;
    p_d      = p_q;
    done_d   = 1'b0;
    result_d = result_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      n_d    = x_i;
      p_d    = 5'd31;
    end else if (busy_q) begin
      if (step_q == LAST_STEP) begin
        busy_d   = 1'b0;
        done_d   = 1'b1;
        result_d = {1'b0, p_q, 10'd0} + LOG_W'(lo) + LOG_W'(interp);
      end else begin
        step_d = step_q + 3'd1;
        if ((n_q & hi_mask) == '0) begin
          n_d = n_q << shamt;
          p_d = p_q - shamt;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q      <= n_d;
    p_q      <= p_d;
    result_q <= result_d;
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

`default_nettype wire

@@ rtl/awlm_ctrl.sv @@
// Sequencer of the level meter: runs the shared log unit over sum and count,
// then scaling, clamping and the hand-off to the output register. Uses awlm_pkg.
`default_nettype none

module awlm_ctrl
  import awlm_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire awlm_stat_t stat_i,
  output awlm_ctrl_t      ctrl_o
);

  awlm_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (stat_i.end_req) state_d = ST_SUM_GO;
      ST_SUM_GO:   state_d = stat_i.is_silent ? ST_DONE : ST_SUM_WAIT;
      ST_SUM_WAIT: if (stat_i.log_done) state_d = ST_CNT_GO;
      ST_CNT_GO:   state_d = ST_CNT_WAIT;
      ST_CNT_WAIT: if (stat_i.log_done) state_d = ST_SCALE;
      ST_SCALE:    state_d = ST_CLAMP;
      ST_CLAMP:    state_d = ST_DONE;
      ST_DONE:     if (stat_i.out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    unique case (state_q)
      ST_IDLE:     ctrl_o.in_ready = 1'b1;
      ST_SUM_GO: begin
        ctrl_o.cap_silent = stat_i.is_silent;
        ctrl_o.log_start  = !stat_i.is_silent;
      end
      ST_SUM_WAIT: ctrl_o.cap_lsum = stat_i.log_done;
      ST_CNT_GO: begin
        ctrl_o.sel_cnt   = 1'b1;
        ctrl_o.log_start = 1'b1;
      end
      ST_CNT_WAIT: ctrl_o.cap_d = stat_i.log_done;
      ST_SCALE:    ctrl_o.cap_prod = 1'b1;
      ST_CLAMP:    ctrl_o.cap_level = 1'b1;
      ST_DONE: begin
        ctrl_o.load_out  = stat_i.out_free;
        ctrl_o.clear_acc = stat_i.out_free;
      end
      default:     ctrl_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/audio_window_level_meter.sv @@
// Top level of the audio window level meter: accumulator, shared log unit,
// sequencer, scaling datapath and output register. Depends on awlm_pkg.
//
// Each sample request adds the sample's magnitude to the window sum, so
// ordinary samples stream at one per clock while the input is ready. The
// request flagged by tlast closes the window: the input then stays not ready
// while the shared log unit (a five-step leading-one search plus one table
// interpolation step) runs once on the sum and once on the count, followed
// by one multiply, one clamp and the load of the output register. A silent
// window skips the log unit, the multiply and the clamp. A finished level
// waits in the output register without blocking new samples; a further
// window end waits only if that register is still full. Samples beyond
// MAX_SAMPLES in one window are ignored, but their tlast still closes it.
`default_nettype none

module audio_window_level_meter
  import awlm_pkg::*;
#(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [SAMPLE_W-1:0]   s_axis_tdata,  // [15:0] sample
  input  wire logic                  s_axis_tlast,  // window_end
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic      [OUT_DATA_W-1:0] m_axis_tdata,  // [12:0] level, [15:13] zero
  output logic                       m_axis_tuser   // [0] silent
);

  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);

  awlm_ctrl_t ctrl;
  awlm_stat_t stat;

  logic             in_req;
  logic [SUM_W-1:0] sum;
  logic [CNT_W-1:0] count;
  logic             log_done;
  logic [LOG_W-1:0] log_res;
  logic [SUM_W-1:0] log_x;

  logic [LOG_W-1:0]         lsum_q;
  logic signed [D_W-1:0]    d_q, d_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [D_W-1:0]    shifted, lvl_wide;
  logic signed [LEVEL_W-1:0] level_q, level_d;
  logic                     silent_q;
  logic [LEVEL_W-1:0]       out_level_q;
  logic                     out_silent_q;
  logic                     out_valid_q;

  assign s_axis_tready = ctrl.in_ready;
  assign in_req        = s_axis_tvalid && ctrl.in_ready;

  awlm_accum #(
    .MAX_SAMPLES(MAX_SAMPLES),
    .CNT_W      (CNT_W)
  ) u_accum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .add_i   (in_req),
    .sample_i(s_axis_tdata),
    .clear_i (ctrl.clear_acc),
    .sum_o   (sum),
    .count_o (count)
  );

  assign log_x = ctrl.sel_cnt ? SUM_W'(count) : sum;

  awlm_log_unit u_log (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctrl.log_start),
    .x_i     (log_x),
    .done_o  (log_done),
    .result_o(log_res)
  );

  always_comb begin
    stat.end_req   = in_req && s_axis_tlast;
    stat.log_done  = log_done;
    stat.is_silent = (sum == '0) || (count == '0);
    stat.out_free  = !out_valid_q || m_axis_tready;
  end

  awlm_ctrl u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .stat_i(stat),
    .ctrl_o(ctrl)
  );

  always_comb begin
    d_d    = $signed({1'b0, lsum_q}) - $signed({1'b0, log_res}) - LOG_OFFSET;
    prod_d = PROD_W'(d_q * $signed({1'b0, DB_FACTOR})) + ROUND_HALF;
    shifted  = D_W'(prod_q >>> 20);
    lvl_wide = shifted + D_W'(LEVEL_TOP);
    if (lvl_wide < D_W'(LEVEL_FLOOR)) begin
      level_d = LEVEL_FLOOR;
    end else if (lvl_wide > D_W'(LEVEL_TOP)) begin
      level_d = LEVEL_TOP;
    end else begin
      level_d = LEVEL_W'(lvl_wide);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.cap_lsum) begin
      lsum_q <= log_res;
    end
    if (ctrl.cap_d) begin
      d_q <= d_d;
    end
    if (ctrl.cap_prod) begin
      prod_q <= prod_d;
    end
    if (ctrl.cap_level) begin
      level_q  <= level_d;
      silent_q <= 1'b0;
    end else if (ctrl.cap_silent) begin
      level_q  <= LEVEL_FLOOR;
      silent_q <= 1'b1;
    end
    if (ctrl.load_out) begin
      out_level_q  <= level_q;
      out_silent_q <= silent_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.load_out) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OUT_DATA_W - LEVEL_W)'(0), out_level_q};
  assign m_axis_tuser  = out_silent_q;

endmodule

`default_nettype wire

@@ rtl/awlm_checker.sv @@
// Port-level checker for the audio window level meter, bound to the top level.
// Depends on awlm_pkg and audio_window_level_meter_defines.svh.
`default_nettype none

`include "audio_window_level_meter_defines.svh"

module awlm_checker
  import awlm_pkg::*;
(
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  s_axis_tvalid,
  input wire logic                  s_axis_tready,
  input wire logic [SAMPLE_W-1:0]   s_axis_tdata,
  input wire logic                  s_axis_tlast,
  input wire logic                  m_axis_tvalid,
  input wire logic                  m_axis_tready,
  input wire logic [OUT_DATA_W-1:0] m_axis_tdata,
  input wire logic                  m_axis_tuser
);

  logic signed [LEVEL_W-1:0] out_level;
  logic                      end_req;

  assign out_level = $signed(m_axis_tdata[LEVEL_W-1:0]);
  assign end_req   = s_axis_tvalid && s_axis_tready && s_axis_tlast
                     && (s_axis_tdata == s_axis_tdata);

  `AWLM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `AWLM_ASSERT_IMP(a_silent_floor, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser, out_level == LEVEL_FLOOR)
  `AWLM_ASSERT_IMP(a_level_range, clk_i, rst_ni, m_axis_tvalid, (out_level <= LEVEL_TOP) && (out_level >= LEVEL_FLOOR) && (m_axis_tdata[OUT_DATA_W-1:LEVEL_W] == '0))
  `AWLM_ASSERT_NEXT(a_busy_after_end, clk_i, rst_ni, end_req, !s_axis_tready)

endmodule

bind audio_window_level_meter awlm_checker u_awlm_checker (.*);

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for audio_window_level_meter: streams PCM sample windows in,
// predicts each window level in fixed point and checks every level result.
// Depends on awlm_pkg and the audio_window_level_meter RTL.

module testbench;
  import awlm_pkg::*;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                window_end;
  } pcm_req_t;

  typedef struct packed {
    logic signed [LEVEL_W-1:0] level;
    logic                      silent;
  } level_res_t;

  localparam int METER_CAP   = 65536;
  localparam int IDLE_LIMIT  = 5000;
  localparam int CALM_TAIL   = 150;
  localparam int DRAIN_WAIT  = 64;

  localparam int LOG2_STEP [0:32] = '{
    0, 45, 90, 132, 174, 214, 254, 292, 330, 366, 402, 436, 470, 504, 536, 568,
    599, 629, 659, 689, 717, 745, 773, 800, 827, 853, 879, 904, 929, 953, 977,
    1001, 1024
  };

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [SAMPLE_W-1:0]   s_axis_tdata = '0;  // [15:0] sample
  logic                  s_axis_tlast = 1'b0;  // window_end
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;  // [12:0] level, [15:13] zero
  logic                  m_axis_tuser;  // [0] silent

  pcm_req_t   pending_reqs[$];
  level_res_t expected_levels[$];
  logic [31:0] win_sum = '0;
  logic [16:0] win_count = '0;
  int mismatches = 0;
  int idle_left = 0;
  int stall_left = 0;
  int quiet_cycles = 0;

  audio_window_level_meter dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic int log2_q10(input logic [31:0] x);
    int p;
    logic [31:0] n;
    int idx;
    int frac;
    int lo;
    int hi;
    if (x == 32'd0) return 0;
    p = 31;
    while (x[p] == 1'b0) p--;
    n = x << (31 - p);
    idx = int'(n[30:26]);
    frac = int'(n[25:18]);
    lo = LOG2_STEP[idx];
    hi = LOG2_STEP[idx + 1];
    return p * 1024 + lo + (((hi - lo) * frac + 128) >>> 8);
  endfunction

  // Accumulates one accepted sample and, on a window end, queues the level it must produce.
  task automatic predict_level(input pcm_req_t req);
    logic [31:0] mag;
    int d;
    longint prod;
    int lvl;
    level_res_t res;
    mag = req.sample[15] ? (32'h10000 - {16'h0, req.sample}) : {16'h0, req.sample};
    if (win_count < METER_CAP) begin
      win_sum = win_sum + mag;
      win_count = win_count + 17'd1;
    end
    if (req.window_end) begin
      if (win_sum == 32'd0 || win_count == 17'd0) begin
        res.level = LEVEL_FLOOR;
        res.silent = 1'b1;
      end else begin
        d = log2_q10(win_sum) - log2_q10({15'h0, win_count}) - 15 * 1024;
        prod = longint'(d) * 64'sd147962 + 64'sd524288;
        lvl = 1920 + int'(prod >>> 20);
        if (lvl < -2560) lvl = -2560;
        if (lvl > 1920) lvl = 1920;
        res.level = lvl[LEVEL_W-1:0];
        res.silent = 1'b0;
      end
      expected_levels.push_back(res);
      win_sum = '0;
      win_count = '0;
    end
  endtask

  task automatic add_req(input logic [15:0] sample, input logic last);
    pcm_req_t req;
    req.sample = sample;
    req.window_end = last;
    pending_reqs.push_back(req);
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h8001;
      3: return 16'h0000;
      4: return 16'(int'($urandom_range(0, 15)) - 8);
      5: return 16'(int'($urandom_range(0, 511)) - 256);
      default: return 16'($urandom);
    endcase
  endfunction

  // Request driver: presents queued samples, with random idle bursts outside the tail.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) predict_level({s_axis_tdata, s_axis_tlast});
      if (!s_axis_tvalid || s_axis_tready) begin
        if (idle_left > 0) begin
          s_axis_tvalid <= 1'b0;
          idle_left--;
        end else if (pending_reqs.size() == 0) begin
          s_axis_tvalid <= 1'b0;
        end else if (pending_reqs.size() >= CALM_TAIL && $urandom_range(0, 7) == 0) begin
          s_axis_tvalid <= 1'b0;
          idle_left = $urandom_range(0, 4);
        end else begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= pending_reqs[0].sample;
          s_axis_tlast <= pending_reqs[0].window_end;
          void'(pending_reqs.pop_front());
        end
      end
    end
  end

  // Result monitor: a field-by-field compare with the oldest level, then random backpressure.
  always @(posedge clk_i) begin
    level_res_t exp_res;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_levels.size() == 0) begin
          if (mismatches < 10)
            $display("Unexpected result: level %0d silent %0b",
                     $signed(m_axis_tdata[12:0]), m_axis_tuser);
          mismatches++;
        end else begin
          exp_res = expected_levels.pop_front();
          if (m_axis_tdata !== {3'b000, exp_res.level} || m_axis_tuser !== exp_res.silent) begin
            if (mismatches < 10)
              $display("Mismatch: expected level %0d silent %0b, got tdata %h silent %0b",
                       exp_res.level, exp_res.silent, m_axis_tdata, m_axis_tuser);
            mismatches++;
          end
        end
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else if (pending_reqs.size() >= CALM_TAIL && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        stall_left = $urandom_range(0, 4);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int total;
    int len;
    int kind;
    logic [15:0] smp;

    // Single-sample windows at the extremes, silent windows and several multi-sample windows.
    add_req(16'h7FFF, 1'b1);
    add_req(16'h8000, 1'b1);
    add_req(16'h8001, 1'b1);
    add_req(16'h0000, 1'b1);
    add_req(16'h0001, 1'b1);
    add_req(16'hFFFF, 1'b1);
    add_req(16'h0000, 1'b0);
    add_req(16'h0000, 1'b0);
    add_req(16'h0000, 1'b1);
    add_req(16'd100, 1'b0);
    add_req(-16'sd100, 1'b0);
    add_req(16'h7FFF, 1'b0);
    add_req(16'h8000, 1'b1);
    add_req(16'h5555, 1'b0);
    add_req(16'hAAAA, 1'b1);
    add_req(16'h8000, 1'b0);
    add_req(16'h8000, 1'b0);
    add_req(16'h8000, 1'b1);

    total = 0;
    while (total < 1332) begin
      kind = $urandom_range(0, 9);
      len = (kind == 0) ? $urandom_range(25, 300) : $urandom_range(1, 24);
      if (len > 1332 - total) len = 1332 - total;
      for (int i = 0; i < len; i++) begin
        smp = (kind == 1) ? 16'h0000 : pick_sample();
        add_req(smp, (i == len - 1) ? 1'b1 : 1'b0);
      end
      total += len;
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i);
    while (pending_reqs.size() != 0 || s_axis_tvalid || expected_levels.size() != 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (mismatches == 0 && expected_levels.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ audio_window_level_meter.f @@
+incdir+rtl
rtl/awlm_pkg.sv
rtl/awlm_accum.sv
rtl/awlm_log_unit.sv
rtl/awlm_ctrl.sv
rtl/audio_window_level_meter.sv
rtl/awlm_checker.sv
tb/testbench.sv
